### rtl/core/bsa_pkg.sv
// Shared types, codes and constants of the bitmap slot allocator.
package bsa_pkg;

   localparam int DEF_PAGE_SHIFT     = 12;
   localparam int DEF_MAX_SLABS      = 64;
   localparam int DEF_WORDS_PER_SLAB = 4;

   localparam int ADDR_W     = 48;
   localparam int POOL_W     = 36;
   localparam int SHIFT_W    = 4;
   localparam int BYTES_W    = 32;
   localparam int FREED_W    = 13;
   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = 6;
   localparam int MIN_SHIFT  = 4;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [POOL_W-1:0]  POOL_PAGE_RESET  = POOL_W'(1);
   localparam logic [SHIFT_W-1:0] SLOT_SHIFT_RESET = SHIFT_W'(4);

   typedef enum logic [1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_FREE   = 2'd1,
      FUNC_RESIZE = 2'd2,
      FUNC_REMAP  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_REFUSED     = 3'd1,
      STAT_FOREIGN     = 3'd2,
      STAT_MISALIGNED  = 3'd3,
      STAT_DOUBLE_FREE = 3'd4
   } status_type;

   typedef enum logic {
      REG_POOL_PAGE  = 1'b0,
      REG_SLOT_SHIFT = 1'b1
   } reg_idx_type;

   typedef struct packed {
      func_type            func;
      logic [BYTES_W-1:0]  byte_count;
      logic                zero_fill;
      logic [ADDR_W-1:0]   address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   slot_address;
      status_type          status;
      logic [FREED_W-1:0]  freed_bytes;
      logic                clear_slot;
   } rsp_type;

   typedef struct packed {
      logic [POOL_W-1:0]   pool_page;
      logic [SHIFT_W-1:0]  slot_shift;
   } cfg_type;

endpackage

### rtl/core/bsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bsa_csr.sv
// Configuration registers of the slot allocator behind an APB-style port.
module bsa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output bsa_pkg::cfg_type                   cfg
);
   import bsa_pkg::*;

   logic [POOL_W-1:0]  pool_page_ff, pool_page_in;
   logic [SHIFT_W-1:0] slot_shift_ff, slot_shift_in;
   reg_idx_type        reg_idx;
   logic               wr_strobe;

   // registers sit on 8-byte boundaries; the low address bits are ignored
   assign reg_idx   = reg_idx_type'(paddr[CSR_ADDR_W-1]);
   assign wr_strobe = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      pool_page_in  = pool_page_ff;
      slot_shift_in = slot_shift_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_POOL_PAGE:  pool_page_in  = pwdata[POOL_W-1:0];
            REG_SLOT_SHIFT: slot_shift_in = pwdata[SHIFT_W-1:0];
            default:        pool_page_in  = pool_page_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_POOL_PAGE:  prdata = CSR_DATA_W'(pool_page_ff);
         REG_SLOT_SHIFT: prdata = CSR_DATA_W'(slot_shift_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_page_ff  <= POOL_PAGE_RESET;
         slot_shift_ff <= SLOT_SHIFT_RESET;
      end else begin
         pool_page_ff  <= pool_page_in;
         slot_shift_ff <= slot_shift_in;
      end
   end

   assign cfg.pool_page  = pool_page_ff;
   assign cfg.slot_shift = slot_shift_ff;

endmodule

### rtl/core/bsa_engine.sv
// Request sequencer: bitmap RAM read-modify-write, full-word summary, slab activation.
module bsa_engine #(
   parameter int PAGE_SHIFT     = bsa_pkg::DEF_PAGE_SHIFT,
   parameter int MAX_SLABS      = bsa_pkg::DEF_MAX_SLABS,
   parameter int WORDS_PER_SLAB = bsa_pkg::DEF_WORDS_PER_SLAB
) (
   input  logic              clock,
   input  logic              reset,
   input  bsa_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  bsa_pkg::req_type  req_data,
   output logic              res_valid,
   input  logic              res_ready,
   output bsa_pkg::rsp_type  res_data
);
   import bsa_pkg::*;

   localparam int DEPTH   = MAX_SLABS * WORDS_PER_SLAB;
   localparam int AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int SLAB_W  = $clog2(MAX_SLABS + 1);
   localparam int WIDX_W  = WORDS_PER_SLAB > 1 ? $clog2(WORDS_PER_SLAB) : 1;
   localparam int SH_W    = $clog2(PAGE_SHIFT + 1);
   localparam int CNT_W   = $clog2(WORDS_PER_SLAB * WORD_BITS +
                                   (1 << (PAGE_SHIFT - MIN_SHIFT)) + 1);
   localparam int PG_W    = ADDR_W - PAGE_SHIFT;
   localparam int CMP_W   = (PG_W > POOL_W ? PG_W : POOL_W) + 1;
   localparam int PAGE_W  = POOL_W + 1;
   localparam int EXT_W   = BYTES_W + 1;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DECODE   = 9'b000000010,
      S_SCAN     = 9'b000000100,
      S_ALLOC_WB = 9'b000001000,
      S_ACTIVATE = 9'b000010000,
      S_FREE_RD  = 9'b000100000,
      S_FREE_WB  = 9'b001000000,
      S_DONE     = 9'b010000000,
      S_SPARE    = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   rsp_type                   res_ff, res_in;
   logic                      clr_ff, clr_in;
   logic [SLAB_W-1:0]         scan_ff, scan_in;
   logic [SLAB_W-1:0]         active_ff, active_in;
   logic [WORDS_PER_SLAB-1:0] skip_ff, skip_in;
   logic [WIDX_W-1:0]         word_ff, word_in;
   logic [AW-1:0]             mem_addr_ff, mem_addr_in;
   logic [WORD_SHIFT-1:0]     bit_ff, bit_in;
   logic [DEPTH-1:0]          full_ff, full_in;

   logic                      ram_wr_en, ram_rd_en;
   logic [AW-1:0]             ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0]      ram_wr_data, ram_rd_data;

   // slot geometry from the current registers
   logic [4:0]                sh_raw, sh_clamp;
   logic [SH_W-1:0]           eff_s;
   logic [PAGE_SHIFT:0]       slot_bytes;
   logic [CNT_W-1:0]          raw_slots, slots;

   // request decode
   logic                      addr_null, bytes_zero, size_big;
   logic                      is_alloc, is_free, alloc_clr;
   logic [PG_W-1:0]           page_hi;
   logic [CMP_W-1:0]          page_diff;
   logic                      page_foreign, misaligned, slot_over;
   logic [PAGE_SHIFT-1:0]     page_off, slot_in;
   logic [AW-1:0]             free_addr;

   // scan and grant
   logic [AW-1:0]             slab_base;
   logic [WORDS_PER_SLAB-1:0] in_range, cand;
   logic [WIDX_W-1:0]         first_w;
   logic [WORD_BITS-1:0]      tail_bits, avail, new_word, act_word;
   logic [WORD_SHIFT-1:0]     first_b;
   logic [PAGE_W-1:0]         page_sum;
   logic                      exhausted;
   logic [PAGE_SHIFT-1:0]     grant_off;
   logic [ADDR_W-1:0]         grant_addr, slab_addr;

   assign sh_raw   = {1'b0, cfg.slot_shift};
   assign sh_clamp = (sh_raw < 5'(MIN_SHIFT))  ? 5'(MIN_SHIFT)  :
                     (sh_raw > 5'(PAGE_SHIFT)) ? 5'(PAGE_SHIFT) : sh_raw;
   assign eff_s      = SH_W'(sh_clamp);
   assign slot_bytes = {{PAGE_SHIFT{1'b0}}, 1'b1} << eff_s;
   assign raw_slots  = CNT_W'(1) << (SH_W'(PAGE_SHIFT) - eff_s);
   assign slots      = (raw_slots > CNT_W'(WORDS_PER_SLAB * WORD_BITS)) ?
                       CNT_W'(WORDS_PER_SLAB * WORD_BITS) : raw_slots;

   assign addr_null  = (req_ff.address == '0);
   assign bytes_zero = (req_ff.byte_count == '0);
   assign size_big   = EXT_W'(req_ff.byte_count) > EXT_W'(slot_bytes);
   assign is_alloc   = (req_ff.func == FUNC_ALLOC) ||
                       ((req_ff.func == FUNC_REMAP) && addr_null);
   assign is_free    = (req_ff.func == FUNC_FREE) ||
                       ((req_ff.func == FUNC_REMAP) && !addr_null && bytes_zero);
   assign alloc_clr  = (req_ff.func == FUNC_ALLOC) ? req_ff.zero_fill : 1'b1;

   assign page_hi      = req_ff.address[ADDR_W-1:PAGE_SHIFT];
   assign page_diff    = CMP_W'(page_hi) - CMP_W'(cfg.pool_page);
   assign page_foreign = (CMP_W'(page_hi) < CMP_W'(cfg.pool_page)) ||
                         (page_diff >= CMP_W'(active_ff));
   assign page_off     = req_ff.address[PAGE_SHIFT-1:0];
   assign misaligned   = |(page_off & (slot_bytes[PAGE_SHIFT-1:0] - PAGE_SHIFT'(1)));
   assign slot_in      = page_off >> eff_s;
   assign slot_over    = 32'(slot_in) >= 32'(slots);
   assign free_addr    = AW'(page_diff) * AW'(WORDS_PER_SLAB) +
                         AW'(slot_in >> WORD_SHIFT);

   assign slab_base = AW'(scan_ff) * AW'(WORDS_PER_SLAB);
   assign page_sum  = PAGE_W'(cfg.pool_page) + PAGE_W'(scan_ff);
   assign exhausted = (active_ff >= SLAB_W'(MAX_SLABS)) || (page_sum == '0) ||
                      (|(page_sum >> PG_W));
   assign slab_addr = ADDR_W'(page_sum) << PAGE_SHIFT;

   always_comb begin
      for (int w = 0; w < WORDS_PER_SLAB; w++) begin
         in_range[w] = CNT_W'(w * WORD_BITS) < slots;
      end
      for (int b = 0; b < WORD_BITS; b++) begin
         tail_bits[b] = CNT_W'({word_ff, WORD_SHIFT'(b)}) >= slots;
      end
   end

   // candidate words: not known full, holding real slots, not rejected this pass
   assign cand = ~full_ff[slab_base +: WORDS_PER_SLAB] & in_range & ~skip_ff;
   assign avail = ~(ram_rd_data | tail_bits);

   always_comb begin
      first_w = '0;
      for (int w = WORDS_PER_SLAB - 1; w >= 0; w--) begin
         if (cand[w]) begin
            first_w = WIDX_W'(w);
         end
      end
   end

   always_comb begin
      first_b = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            first_b = WORD_SHIFT'(b);
         end
      end
   end

   assign new_word   = ram_rd_data | (WORD_BITS'(1) << first_b);
   assign act_word   = tail_bits | ((word_ff == '0) ? WORD_BITS'(1) : '0);
   assign grant_off  = PAGE_SHIFT'({word_ff, first_b}) << eff_s;
   assign grant_addr = slab_addr | ADDR_W'(grant_off);

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      res_in      = res_ff;
      clr_in      = clr_ff;
      scan_in     = scan_ff;
      active_in   = active_ff;
      skip_in     = skip_ff;
      word_in     = word_ff;
      mem_addr_in = mem_addr_ff;
      bit_in      = bit_ff;
      full_in     = full_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = slab_base + AW'(first_w);
      ram_wr_en   = 1'b0;
      ram_wr_addr = slab_base + AW'(word_ff);
      ram_wr_data = new_word;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in        = '0;
            res_in.status = STAT_OK;
            state_in      = S_DONE;
            if (is_alloc) begin
               clr_in = alloc_clr;
               if (bytes_zero || size_big) begin
                  res_in.status = STAT_REFUSED;
               end else begin
                  scan_in  = '0;
                  skip_in  = '0;
                  state_in = S_SCAN;
               end
            end else if (is_free) begin
               if (addr_null) begin
                  res_in.status = STAT_OK;
               end else if (page_foreign) begin
                  res_in.status = STAT_FOREIGN;
               end else if (misaligned) begin
                  res_in.status = STAT_MISALIGNED;
               end else if (slot_over) begin
                  res_in.status = STAT_FOREIGN;
               end else begin
                  mem_addr_in = free_addr;
                  bit_in      = slot_in[WORD_SHIFT-1:0];
                  state_in    = S_FREE_RD;
               end
            end else if (size_big) begin
               res_in.status = STAT_REFUSED;
            end else begin
               res_in.slot_address = req_ff.address;
            end
         end
         S_SCAN: begin
            if (scan_ff >= active_ff) begin
               if (exhausted) begin
                  res_in        = '0;
                  res_in.status = STAT_REFUSED;
                  state_in      = S_DONE;
               end else begin
                  word_in  = '0;
                  state_in = S_ACTIVATE;
               end
            end else if (|cand) begin
               word_in   = first_w;
               ram_rd_en = 1'b1;
               state_in  = S_ALLOC_WB;
            end else begin
               scan_in = scan_ff + SLAB_W'(1);
               skip_in = '0;
            end
         end
         S_ALLOC_WB: begin
            if (avail == '0) begin
               // free bits lie only past the slot count: drop this word, keep scanning
               skip_in[word_ff] = 1'b1;
               state_in         = S_SCAN;
            end else begin
               ram_wr_en            = 1'b1;
               full_in[ram_wr_addr] = &new_word;
               res_in               = '0;
               res_in.status        = STAT_OK;
               res_in.slot_address  = grant_addr;
               res_in.clear_slot    = clr_ff;
               state_in             = S_DONE;
            end
         end
         S_ACTIVATE: begin
            ram_wr_en            = 1'b1;
            ram_wr_data          = act_word;
            full_in[ram_wr_addr] = &act_word;
            if (word_ff == WIDX_W'(WORDS_PER_SLAB - 1)) begin
               active_in           = active_ff + SLAB_W'(1);
               res_in              = '0;
               res_in.status       = STAT_OK;
               res_in.slot_address = slab_addr;
               res_in.clear_slot   = clr_ff;
               state_in            = S_DONE;
            end else begin
               word_in = word_ff + WIDX_W'(1);
            end
         end
         S_FREE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = mem_addr_ff;
            state_in    = S_FREE_WB;
         end
         S_FREE_WB: begin
            if (!ram_rd_data[bit_ff]) begin
               res_in.status = STAT_DOUBLE_FREE;
            end else begin
               ram_wr_en            = 1'b1;
               ram_wr_addr          = mem_addr_ff;
               ram_wr_data          = ram_rd_data & ~(WORD_BITS'(1) << bit_ff);
               full_in[mem_addr_ff] = 1'b0;
               res_in.status        = STAT_OK;
               res_in.freed_bytes   = FREED_W'(slot_bytes);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= '0;
         full_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      clr_ff      <= clr_in;
      scan_ff     <= scan_in;
      skip_ff     <= skip_in;
      word_ff     <= word_in;
      mem_addr_ff <= mem_addr_in;
      bit_ff      <= bit_in;
   end

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

### rtl/core/bitmap_slot_allocator_top.sv
// Top level of the bitmap slot allocator: config port, sequencer and result register.
//
//  port group   dir  handshake                      payload
//  req_*        in   req_valid / req_ready          req_data   (bsa_pkg::req_type)
//  rsp_*        out  rsp_valid / rsp_ready          rsp_data   (bsa_pkg::rsp_type)
//  APB          in   psel, penable, pwrite / pready paddr, pwdata, prdata (64 bit)
//
// One request at a time. Resize, null and rejected frees go from decode straight to the
// result register; a bitmap free reads its bitmap word and writes it back; a granted
// allocate scans the active slabs by the full-word summary, reads a candidate word and
// writes the granted bit back, trying the next candidate when a word has no usable free
// bit; opening a new slab writes its WORDS_PER_SLAB bitmap words one after another.
// Reset is synchronous; no clearing pass is needed since a slab's words are
// written on activation. A new request is taken while a result waits in the
// result register; the sequencer stalls only when it holds a second result.
module bitmap_slot_allocator_top #(
   parameter int PAGE_SHIFT     = bsa_pkg::DEF_PAGE_SHIFT,
   parameter int MAX_SLABS      = bsa_pkg::DEF_MAX_SLABS,
   parameter int WORDS_PER_SLAB = bsa_pkg::DEF_WORDS_PER_SLAB
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bsa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bsa_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import bsa_pkg::*;

   cfg_type cfg;
   logic    res_valid, res_ready;
   rsp_type res_data;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   bsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bsa_engine #(
      .PAGE_SHIFT     (PAGE_SHIFT),
      .MAX_SLABS      (MAX_SLABS),
      .WORDS_PER_SLAB (WORDS_PER_SLAB)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // take a result whenever the output register is empty or draining
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_freed_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.freed_bytes != '0) |->
         (rsp_data.status == STAT_OK) && (rsp_data.slot_address == '0))
      else $error("freed size on a failed or address-carrying result");

   a_clear_is_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clear_slot |->
         (rsp_data.status == STAT_OK) && (rsp_data.freed_bytes == '0))
      else $error("clear flag on a result that grants no slot");

   a_fail_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_OK) |->
         (rsp_data.slot_address == '0) && !rsp_data.clear_slot &&
         (rsp_data.freed_bytes == '0))
      else $error("failed result carries an address, clear flag or size");

endmodule
